@@ sv/mlpq_pkg.sv @@
package mlpq_pkg;

  localparam int NUM_LANES   = 8;
  localparam int LANE_DEPTH  = 16;
  localparam int TAG_BITS    = 16;
  localparam int PRIO_BITS   = 4;

  localparam int LANE_W      = $clog2(NUM_LANES);
  localparam int SLOT_W      = $clog2(LANE_DEPTH);
  localparam int FILL_W      = $clog2(LANE_DEPTH + 1);
  localparam int ADDR_W      = LANE_W + SLOT_W;
  localparam int ENTRY_W     = PRIO_BITS + TAG_BITS;
  localparam int STORE_DEPTH = NUM_LANES * LANE_DEPTH;

  // bits of the request fields that survive masking
  localparam int PRIO_KEEP   = (PRIO_BITS < 4) ? PRIO_BITS : 4;
  localparam int TAG_KEEP    = (TAG_BITS < 16) ? TAG_BITS : 16;

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_TOGGLE = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_LAST    = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_DQ_HEAD,
    S_SH_RD,
    S_SH_WR,
    S_CL_RD,
    S_CL_PICK,
    S_DONE
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [3:0]  lane;
    logic [3:0]  priority_req;
    logic [15:0] customer_tag;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] served_tag;
    logic [3:0]  served_priority;
    logic        lane_now_open;
    logic [4:0]  moved_count;
    logic [4:0]  dropped_count;
  } res_t;

  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

endpackage

@@ sv/multi_lane_priority_queue_rebalance.sv @@
// invalid, refused and open requests go straight to the result; enqueue moves each entry
//   of higher priority value up one slot (one read per slot) and writes the new one below
//   them or in slot zero; dequeue reads the head, then moves each later entry down a slot
// close: each old entry is put into the shortest open lane as above, or dropped if it is full
// throughput: one request at a time; the entry store read/write per step sets the pace
// result held in an output register, so the next request is taken while it waits
// reset (rst, synchronous): every lane open and empty, store contents left undefined
module multi_lane_priority_queue_rebalance
  import mlpq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  state_t state, state_next;

  // per-lane bookkeeping lives in flops, entries in the ram
  logic [FILL_W-1:0] fill      [NUM_LANES];
  logic [FILL_W-1:0] fill_next [NUM_LANES];
  logic [NUM_LANES-1:0] lane_open, lane_open_next;

  // request context
  logic [LANE_W-1:0] op_lane, op_lane_next;
  logic              lane_ok, lane_ok_next;
  status_t           status, status_next;
  entry_t            served, served_next;

  // insertion / shift walker
  logic [LANE_W-1:0] ins_lane, ins_lane_next;
  logic [FILL_W-1:0] ins_k, ins_k_next;
  entry_t            ins_ent, ins_ent_next;
  logic              from_close, from_close_next;

  // close walker
  logic [FILL_W-1:0] src_k, src_k_next;
  logic [FILL_W-1:0] src_n, src_n_next;
  logic [FILL_W-1:0] moved, moved_next;
  logic [FILL_W-1:0] dropped, dropped_next;

  res_t res_next;
  logic res_valid_next;

  // entry store port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  // decoded request
  logic              in_lane_ok;
  logic [LANE_W-1:0] in_lane;
  entry_t            in_ent;

  // shortest open lane
  logic [LANE_W-1:0] best;
  logic [FILL_W-1:0] best_fill;
  logic              best_found;

  logic accept, res_load, ins_rd_done, ins_chk_shift;
  logic fill_err;

  mlpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  function automatic logic [ADDR_W-1:0] mk_addr(logic [LANE_W-1:0] ln, logic [FILL_W-1:0] k);
    mk_addr = {ln, k[SLOT_W-1:0]};
  endfunction

  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign in_lane_ok = (int'(req.lane) < NUM_LANES);
  assign in_lane    = req.lane[LANE_W-1:0];
  assign in_ent.prio = PRIO_BITS'(req.priority_req[PRIO_KEEP-1:0]);
  assign in_ent.tag  = TAG_BITS'(req.customer_tag[TAG_KEEP-1:0]);

  // output register free to take the finished result
  assign res_load = (state == S_DONE) && (!res_valid || res_ready);

  // insertion reaches slot zero, or the entry below is larger and moves up
  assign ins_rd_done   = (ins_k == '0);
  assign ins_chk_shift = (ram_rdata.prio > ins_ent.prio);

  // lowest fill among open lanes, lowest index on ties
  always_comb begin
    best       = '0;
    best_fill  = '0;
    best_found = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (lane_open[i] && (!best_found || fill[i] < best_fill)) begin
        best       = LANE_W'(i);
        best_fill  = fill[i];
        best_found = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DONE;
          if (in_lane_ok) begin
            unique case (req.mode)
              MODE_ENQ: begin
                if (fill[in_lane] < FILL_W'(LANE_DEPTH)) state_next = S_INS_RD;
              end
              MODE_DEQ: begin
                if (lane_open[in_lane] && fill[in_lane] != '0) state_next = S_DQ_HEAD;
              end
              MODE_TOGGLE: begin
                if (lane_open[in_lane] && $countones(lane_open) > 1) state_next = S_CL_RD;
              end
              default: state_next = S_DONE;
            endcase
          end
        end
      end
      S_INS_RD: begin
        if (!ins_rd_done) state_next = S_INS_CHK;
        else              state_next = from_close ? S_CL_RD : S_DONE;
      end
      S_INS_CHK: begin
        if (ins_chk_shift) state_next = S_INS_RD;
        else               state_next = from_close ? S_CL_RD : S_DONE;
      end
      S_DQ_HEAD: state_next = S_SH_RD;
      S_SH_RD: begin
        state_next = (ins_k < fill[op_lane]) ? S_SH_WR : S_DONE;
      end
      S_SH_WR: state_next = S_SH_RD;
      S_CL_RD: begin
        state_next = (src_k < src_n) ? S_CL_PICK : S_DONE;
      end
      S_CL_PICK: begin
        state_next = (best_fill < FILL_W'(LANE_DEPTH)) ? S_INS_RD : S_CL_RD;
      end
      S_DONE: begin
        if (res_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    fill_next       = fill;
    lane_open_next  = lane_open;
    op_lane_next    = op_lane;
    lane_ok_next    = lane_ok;
    status_next     = status;
    served_next     = served;
    ins_lane_next   = ins_lane;
    ins_k_next      = ins_k;
    ins_ent_next    = ins_ent;
    from_close_next = from_close;
    src_k_next      = src_k;
    src_n_next      = src_n;
    moved_next      = moved;
    dropped_next    = dropped;
    res_next        = res;
    res_valid_next  = res_valid && !res_ready;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = ins_ent;
    ram_raddr       = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_lane_next    = in_lane;
          lane_ok_next    = in_lane_ok;
          status_next     = ST_OK;
          served_next     = '0;
          moved_next      = '0;
          dropped_next    = '0;
          from_close_next = 1'b0;
          if (!in_lane_ok) begin
            status_next = ST_INVALID;
          end else begin
            unique case (req.mode)
              MODE_ENQ: begin
                if (fill[in_lane] >= FILL_W'(LANE_DEPTH)) begin
                  status_next = ST_FULL;
                end else begin
                  ins_lane_next = in_lane;
                  ins_k_next    = fill[in_lane];
                  ins_ent_next  = in_ent;
                end
              end
              MODE_DEQ: begin
                if (!lane_open[in_lane] || fill[in_lane] == '0) begin
                  status_next = ST_EMPTY;
                end else begin
                  ram_raddr = mk_addr(in_lane, '0);
                end
              end
              MODE_TOGGLE: begin
                if (lane_open[in_lane] && $countones(lane_open) <= 1) begin
                  status_next = ST_LAST;
                end else if (!lane_open[in_lane]) begin
                  lane_open_next[in_lane] = 1'b1;
                end else begin
                  // close: lane empties at once, its old entries are walked from the ram
                  lane_open_next[in_lane] = 1'b0;
                  fill_next[in_lane]      = '0;
                  src_n_next              = fill[in_lane];
                  src_k_next              = '0;
                end
              end
              default: status_next = ST_INVALID;
            endcase
          end
        end
      end

      S_INS_RD: begin
        if (ins_rd_done) begin
          ram_we    = 1'b1;
          ram_waddr = mk_addr(ins_lane, '0);
          ram_wdata = ins_ent;
          fill_next[ins_lane] = fill[ins_lane] + 1'b1;
          if (from_close) begin
            moved_next = moved + 1'b1;
            src_k_next = src_k + 1'b1;
          end
        end else begin
          ram_raddr = mk_addr(ins_lane, FILL_W'(ins_k - 1'b1));
        end
      end

      S_INS_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = mk_addr(ins_lane, ins_k);
        if (ins_chk_shift) begin
          // larger value moves up one slot
          ram_wdata  = ram_rdata;
          ins_k_next = ins_k - 1'b1;
        end else begin
          ram_wdata = ins_ent;
          fill_next[ins_lane] = fill[ins_lane] + 1'b1;
          if (from_close) begin
            moved_next = moved + 1'b1;
            src_k_next = src_k + 1'b1;
          end
        end
      end

      S_DQ_HEAD: begin
        served_next = ram_rdata;
        ins_k_next  = FILL_W'(1);
      end

      S_SH_RD: begin
        if (ins_k < fill[op_lane]) begin
          ram_raddr = mk_addr(op_lane, ins_k);
        end else begin
          fill_next[op_lane] = fill[op_lane] - 1'b1;
        end
      end

      S_SH_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = mk_addr(op_lane, FILL_W'(ins_k - 1'b1));
        ram_wdata  = ram_rdata;
        ins_k_next = ins_k + 1'b1;
      end

      S_CL_RD: begin
        if (src_k < src_n) ram_raddr = mk_addr(op_lane, src_k);
      end

      S_CL_PICK: begin
        if (best_fill < FILL_W'(LANE_DEPTH)) begin
          ins_lane_next   = best;
          ins_k_next      = best_fill;
          ins_ent_next    = ram_rdata;
          from_close_next = 1'b1;
        end else begin
          dropped_next = dropped + 1'b1;
          src_k_next   = src_k + 1'b1;
        end
      end

      S_DONE: begin
        if (res_load) begin
          res_valid_next           = 1'b1;
          res_next.status          = status;
          res_next.served_tag      = 16'(served.tag);
          res_next.served_priority = 4'(served.prio);
          res_next.lane_now_open   = lane_ok && lane_open[op_lane];
          res_next.moved_count     = 5'(moved);
          res_next.dropped_count   = 5'(dropped);
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lane_open <= '1;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        fill[i] <= '0;
      end
    end else begin
      state     <= state_next;
      lane_open <= lane_open_next;
      res_valid <= res_valid_next;
      fill      <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    op_lane    <= op_lane_next;
    lane_ok    <= lane_ok_next;
    status     <= status_next;
    served     <= served_next;
    ins_lane   <= ins_lane_next;
    ins_k      <= ins_k_next;
    ins_ent    <= ins_ent_next;
    from_close <= from_close_next;
    src_k      <= src_k_next;
    src_n      <= src_n_next;
    moved      <= moved_next;
    dropped    <= dropped_next;
    res        <= res_next;
  end

  always_comb begin
    fill_err = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (fill[i] > FILL_W'(LANE_DEPTH)) fill_err = 1'b1;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) !fill_err)
    else $error("lane fill above depth");

  a_one_open: assert property (@(posedge clk) disable iff (rst) lane_open != '0)
    else $error("no lane left open");

  a_pick_open: assert property (@(posedge clk) disable iff (rst)
    (state == S_CL_PICK) |-> (best_found && best != op_lane))
    else $error("rebalance target not an open lane");

  a_chk_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_CHK) |-> (ins_k != '0))
    else $error("insertion compare at slot zero");

  a_moves_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CL_RD) |-> (src_k <= src_n && moved + dropped == src_k))
    else $error("rebalance counts out of step");

endmodule

@@ sv/mlpq_ram.sv @@
module mlpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
